### hdl/md5_pkg.sv
`default_nettype none

package md5_pkg;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5_out_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_abcd_t;

  // read side control of the block buffer during padding
  typedef struct packed {
    logic        fin;
    logic        pass;
    logic [5:0]  pos;
    logic [63:0] bit_len;
  } md5_rd_ctl_t;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StRound = 4'b0010,
    StAdd   = 4'b0100,
    StEmit  = 4'b1000
  } md5_state_e;

  localparam md5_abcd_t ChainIv = '{
    a: 32'h67452301,
    b: 32'hefcdab89,
    c: 32'h98badcfe,
    d: 32'h10325476
  };

  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [5:0] LastPos   = 6'd63;
  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [3:0] LenLoIdx  = 4'd14;
  localparam logic [1:0] LastWord  = 2'd3;

  localparam logic [4:0] ShiftTab [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  localparam logic [31:0] RoundK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
    return ShiftTab[{rnd[5:4], rnd[1:0]}];
  endfunction

  function automatic md5_abcd_t abcd_add(input md5_abcd_t x, input md5_abcd_t y);
    md5_abcd_t s;
    s.a = x.a + y.a;
    s.b = x.b + y.b;
    s.c = x.c + y.c;
    s.d = x.d + y.d;
    return s;
  endfunction

endpackage

`default_nettype wire

### hdl/md5_msg_buf.sv
`default_nettype none

module md5_msg_buf import md5_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        wr_en_i,
  input  wire logic [5:0]  wr_pos_i,
  input  wire logic [7:0]  wr_byte_i,
  input  wire logic [3:0]  rd_idx_i,
  input  wire md5_rd_ctl_t rd_ctl_i,
  output logic      [31:0] rd_word_o
);

  logic [31:0] blk_q [16];
  logic [31:0] stored;
  logic [31:0] padded;
  logic [31:0] len_word;
  logic        len_slot;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      blk_q[wr_pos_i[5:2]][{wr_pos_i[1:0], 3'b000} +: 8] <= wr_byte_i;
    end
  end

  assign stored   = blk_q[rd_idx_i];
  assign len_slot = (rd_idx_i[3:1] == LenLoIdx[3:1]);
  assign len_word = rd_idx_i[0] ? rd_ctl_i.bit_len[63:32] : rd_ctl_i.bit_len[31:0];

  // bytes past the end of the message: pad marker then zeros
  always_comb begin
    logic [5:0] bpos;
    padded = '0;
    for (int k = 0; k < 4; k++) begin
      bpos = {rd_idx_i, 2'(k)};
      if (bpos < rd_ctl_i.pos) begin
        padded[8*k +: 8] = stored[8*k +: 8];
      end else if (bpos == rd_ctl_i.pos) begin
        padded[8*k +: 8] = PadByte;
      end
    end
  end

  always_comb begin
    if (!rd_ctl_i.fin) begin
      rd_word_o = stored;
    end else if (len_slot && (rd_ctl_i.pass || (rd_ctl_i.pos[5:3] != 3'b111))) begin
      rd_word_o = len_word;
    end else if (rd_ctl_i.pass) begin
      rd_word_o = '0;
    end else begin
      rd_word_o = padded;
    end
  end

endmodule

`default_nettype wire

### hdl/md5_round.sv
`default_nettype none

module md5_round import md5_pkg::*; (
  input  wire md5_abcd_t   abcd_i,
  input  wire logic [5:0]  rnd_i,
  input  wire logic [31:0] msg_i,
  output logic      [3:0]  msg_idx_o,
  output md5_abcd_t        abcd_o
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] rot;
  logic [4:0]  sh;
  logic [5:0]  rsh;
  logic [3:0]  r4;

  assign r4 = rnd_i[3:0];

  always_comb begin
    unique case (rnd_i[5:4])
      2'd0: begin
        f         = (abcd_i.b & abcd_i.c) | (~abcd_i.b & abcd_i.d);
        msg_idx_o = r4;
      end
      2'd1: begin
        f         = (abcd_i.b & abcd_i.d) | (abcd_i.c & ~abcd_i.d);
        msg_idx_o = 4'(r4 * 4'd5 + 4'd1);
      end
      2'd2: begin
        f         = abcd_i.b ^ abcd_i.c ^ abcd_i.d;
        msg_idx_o = 4'(r4 * 4'd3 + 4'd5);
      end
      default: begin
        f         = abcd_i.c ^ (abcd_i.b | ~abcd_i.d);
        msg_idx_o = 4'(r4 * 4'd7);
      end
    endcase
  end

  assign sum = abcd_i.a + f + RoundK[rnd_i] + msg_i;
  assign sh  = rot_amt(rnd_i);
  assign rsh = 6'd32 - {1'b0, sh};
  assign rot = (sum << sh) | (sum >> rsh);

  assign abcd_o.a = abcd_i.d;
  assign abcd_o.b = abcd_i.b + rot;
  assign abcd_o.c = abcd_i.b;
  assign abcd_o.d = abcd_i.c;

endmodule

`default_nettype wire

### hdl/md5_message_digest.sv
// md5 digest of a byte stream
// input channel: one beat per message byte (mode 0) or a finish beat (mode 1);
// a beat is taken when in_valid_i is high and in_stall_o is low
// an absorb beat is stored in the block buffer; the one completing a 64-byte block
// also starts a compression: 64 rounds on the single round unit,
// one round per cycle, then an add into the chaining words
// a finish beat runs the padded final block and, when eight or
// fewer bytes of room are left, an extra length block
// the digest then leaves as four output beats, words a to d, last_word on d;
// at most one output beat per cycle, held as long as out_stall_i is high
// in_stall_o stays high while a compression runs, and after a finish beat until
// the last digest beat has been taken; the chaining words and byte count are
// then back at their initial values, ready for the next message
// rst_ni clears the sequencer and byte count and restores the initial chaining words at once
`default_nettype none

module md5_message_digest import md5_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire md5_in_t  in_beat_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output md5_out_t      out_beat_o
);

  md5_state_e  state_q, state_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [63:0] cnt_q, cnt_d;
  md5_abcd_t   chain_q, chain_d;
  md5_abcd_t   work_q, work_d;
  logic        fin_q, fin_d;
  logic        pass_q, pass_d;
  logic [1:0]  widx_q, widx_d;

  logic        in_acc;
  logic        out_acc;
  logic [5:0]  pos;
  logic [3:0]  msg_idx;
  logic [31:0] msg_word;
  md5_abcd_t   rnd_out;
  md5_abcd_t   chain_sum;
  md5_rd_ctl_t rd_ctl;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == StEmit);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign pos         = cnt_q[5:0];

  assign rd_ctl.fin     = fin_q;
  assign rd_ctl.pass    = pass_q;
  assign rd_ctl.pos     = pos;
  assign rd_ctl.bit_len = {cnt_q[60:0], 3'b000};

  md5_msg_buf u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc && !in_beat_i.mode),
    .wr_pos_i  (pos),
    .wr_byte_i (in_beat_i.data_byte),
    .rd_idx_i  (msg_idx),
    .rd_ctl_i  (rd_ctl),
    .rd_word_o (msg_word)
  );

  md5_round u_round (
    .abcd_i    (work_q),
    .rnd_i     (rnd_q),
    .msg_i     (msg_word),
    .msg_idx_o (msg_idx),
    .abcd_o    (rnd_out)
  );

  assign chain_sum = abcd_add(chain_q, work_q);

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    cnt_d   = cnt_q;
    chain_d = chain_q;
    work_d  = work_q;
    fin_d   = fin_q;
    pass_d  = pass_q;
    widx_d  = widx_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_beat_i.mode) begin
            fin_d   = 1'b1;
            pass_d  = 1'b0;
            work_d  = chain_q;
            rnd_d   = '0;
            state_d = StRound;
          end else begin
            cnt_d = cnt_q + 64'd1;
            if (pos == LastPos) begin
              work_d  = chain_q;
              rnd_d   = '0;
              state_d = StRound;
            end
          end
        end
      end
      StRound: begin
        work_d = rnd_out;
        rnd_d  = rnd_q + 6'd1;
        if (rnd_q == LastRound) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        chain_d = chain_sum;
        work_d  = chain_sum;
        rnd_d   = '0;
        if (!fin_q) begin
          state_d = StIdle;
        end else if (!pass_q && (pos[5:3] == 3'b111)) begin
          pass_d  = 1'b1;
          state_d = StRound;
        end else begin
          widx_d  = '0;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_acc) begin
          widx_d = widx_q + 2'd1;
          if (widx_q == LastWord) begin
            chain_d = ChainIv;
            cnt_d   = '0;
            fin_d   = 1'b0;
            pass_d  = 1'b0;
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rnd_q   <= '0;
      cnt_q   <= '0;
      chain_q <= ChainIv;
      fin_q   <= 1'b0;
      pass_q  <= 1'b0;
      widx_q  <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      cnt_q   <= cnt_d;
      chain_q <= chain_d;
      fin_q   <= fin_d;
      pass_q  <= pass_d;
      widx_q  <= widx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  always_comb begin
    out_beat_o.word_index = widx_q;
    out_beat_o.last_word  = (widx_q == LastWord);
    unique case (widx_q)
      2'd0:    out_beat_o.digest_word = chain_q.a;
      2'd1:    out_beat_o.digest_word = chain_q.b;
      2'd2:    out_beat_o.digest_word = chain_q.c;
      default: out_beat_o.digest_word = chain_q.d;
    endcase
  end

  // block boundary starts a compression
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_beat_i.mode && (pos == LastPos)) |=> (state_q == StRound && rnd_q == '0))
    else $error("full block did not start compression");

  // finish starts the padded block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_beat_i.mode) |=> (state_q == StRound && fin_q && !pass_q))
    else $error("finish did not start padding");

  // last round hands over to the chaining add
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound && rnd_q == LastRound) |=> (state_q == StAdd))
    else $error("round count overran");

  // message state is back to initial after the last digest beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_beat_o.last_word) |=> (chain_q == ChainIv && cnt_q == '0 && !fin_q))
    else $error("state not restored after digest");

  // no absorbed bytes while a digest is being computed or sent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_q && !out_acc) |=> $stable(cnt_q))
    else $error("byte count moved during finish");

endmodule

`default_nettype wire
